### design/smoke_dust_drift_corrector_defines.svh
// Assertion macros for the smoke dust drift corrector.
// Depends on nothing; taken in by the top level.
`ifndef SMOKE_DUST_DRIFT_CORRECTOR_DEFINES_SVH
`define SMOKE_DUST_DRIFT_CORRECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdc assertion failed");

// Next-cycle implication, disabled during reset.
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdc assertion failed");

`endif

### design/sdc_pkg.sv
// Shared constants, types and sequencer states of the smoke dust drift corrector.
// Depends on nothing.
`timescale 1ns / 1ps

package sdc_pkg;

   localparam int WEEK_DEPTH  = 168;
   localparam int DAY_HOURS   = 24;
   localparam int WEEK_IDX_W  = $clog2(WEEK_DEPTH);
   localparam int WEEK_CNT_W  = $clog2(WEEK_DEPTH + 1);
   localparam int WEEK_SUM_W  = $clog2(WEEK_DEPTH * 65535 + 1);
   localparam int HOURS_W     = 5;

   localparam int SAMPLE_W    = 16;
   localparam int FACTOR_W    = 7;
   localparam int CORR_W      = 17;
   localparam int PROD_W      = SAMPLE_W + FACTOR_W;
   localparam int DIVIDEND_W  = 32;
   localparam int DIVISOR_W   = 16;

   localparam int MUL_STEPS   = FACTOR_W;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [SAMPLE_W-1:0] EMPTY_MARK   = 16'hFFFF;
   localparam logic [FACTOR_W-1:0] FACTOR_UNITY = 7'd100;
   localparam logic [FACTOR_W-1:0] FACTOR_MIN   = 7'd80;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 7'd120;
   localparam logic [16:0]         CLEAN_MARGIN = 17'd200;
   localparam logic [31:0]         RISE_LIMIT   = 32'd105;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPH       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE     = 2'd2;

   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] a;
      logic [FACTOR_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                clear;
      logic                push;
      logic [SAMPLE_W-1:0] mean;
   } week_req_type;

   typedef struct packed {
      logic                  done;
      logic [WEEK_SUM_W-1:0] sum;
      logic [WEEK_CNT_W-1:0] count;
   } week_sts_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_MUL_C = 11'b00000000010,
      ST_DIV_C = 11'b00000000100,
      ST_DIV_H = 11'b00000001000,
      ST_PUSH  = 11'b00000010000,
      ST_DIV_W = 11'b00000100000,
      ST_DEC   = 11'b00001000000,
      ST_MUL_R = 11'b00010000000,
      ST_DIV_R = 11'b00100000000,
      ST_MUL_F = 11'b01000000000,
      ST_DIV_F = 11'b10000000000
   } state_type;

endpackage

### design/sdc_req_if.sv
// Sample channel: valid/ready handshake carrying one raw smoke sample.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

interface sdc_req_if;
   logic                         valid;
   logic                         ready;
   logic [sdc_pkg::SAMPLE_W-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

### design/sdc_rsp_if.sv
// Result channel: valid/ready handshake carrying one corrected sample.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

interface sdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sdc_pkg::CORR_W-1:0]   corrected_value;
   logic [sdc_pkg::FACTOR_W-1:0] correction_factor;
   logic                         dust_removed;
   logic                         hour_closed;
   logic                         factor_recalculated;

   modport source (output valid, output corrected_value, output correction_factor,
                   output dust_removed, output hour_closed, output factor_recalculated,
                   input ready);
   modport sink   (input valid, input corrected_value, input correction_factor,
                   input dust_removed, input hour_closed, input factor_recalculated,
                   output ready);
endinterface

### design/sdc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on sdc_pkg.
`timescale 1ns / 1ps

module sdc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  sdc_pkg::mul_req_type       req,
   output logic                       done,
   output logic [sdc_pkg::PROD_W-1:0] product
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [sdc_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sdc_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [sdc_pkg::PROD_W-1:0]    a_ff, a_in;
   logic [sdc_pkg::FACTOR_W-1:0]  b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = sdc_pkg::PROD_W'(req.a);
         b_in    = req.b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[sdc_pkg::PROD_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[sdc_pkg::FACTOR_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sdc_pkg::MUL_CNT_W'(sdc_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### design/sdc_div.sv
// Restoring divider, one quotient bit per cycle; shared by every quotient.
// Depends on sdc_pkg. The divisor must be non-zero.
`timescale 1ns / 1ps

module sdc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  sdc_pkg::div_req_type           req,
   output logic                           done,
   output logic [sdc_pkg::DIVIDEND_W-1:0] quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sdc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sdc_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [sdc_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [sdc_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [sdc_pkg::DIVISOR_W:0]    shifted;
   logic [sdc_pkg::DIVISOR_W:0]    trial;

   assign shifted = {rem_ff, quo_ff[sdc_pkg::DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // keep the trial difference only when it did not go negative
         if (!trial[sdc_pkg::DIVISOR_W]) begin
            rem_in = trial[sdc_pkg::DIVISOR_W-1:0];
         end else begin
            rem_in = shifted[sdc_pkg::DIVISOR_W-1:0];
         end
         quo_in = {quo_ff[sdc_pkg::DIVIDEND_W-2:0], ~trial[sdc_pkg::DIVISOR_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sdc_pkg::DIV_CNT_W'(sdc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### design/sdc_week.sv
// Week ring of hour means with valid bits, running sum and count.
// Depends on sdc_pkg. A push first reads the old entry, then writes the new one.
`timescale 1ns / 1ps

module sdc_week (
   input  logic                  clock,
   input  logic                  reset,
   input  sdc_pkg::week_req_type req,
   output sdc_pkg::week_sts_type sts
);

   logic [sdc_pkg::SAMPLE_W-1:0]   mem [sdc_pkg::WEEK_DEPTH];
   logic [sdc_pkg::SAMPLE_W-1:0]   rd_data_ff;
   logic [sdc_pkg::SAMPLE_W-1:0]   mean_ff, mean_in;
   logic [sdc_pkg::WEEK_DEPTH-1:0] valid_ff, valid_in;
   logic [sdc_pkg::WEEK_IDX_W-1:0] pos_ff, pos_in;
   logic [sdc_pkg::WEEK_SUM_W-1:0] sum_ff, sum_in;
   logic [sdc_pkg::WEEK_CNT_W-1:0] count_ff, count_in;
   logic                           phase_ff, phase_in;
   logic                           done_ff, done_in;
   logic                           keep;
   logic                           old_valid;

   assign keep      = (mean_ff != sdc_pkg::EMPTY_MARK);
   assign old_valid = valid_ff[pos_ff];

   always_comb begin
      mean_in  = mean_ff;
      valid_in = valid_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      phase_in = 1'b0;
      done_in  = 1'b0;
      if (req.clear) begin
         valid_in = '0;
         pos_in   = '0;
         sum_in   = '0;
         count_in = '0;
      end else if (req.push) begin
         mean_in  = req.mean;
         phase_in = 1'b1;
      end else if (phase_ff) begin
         sum_in   = sum_ff
                  - (old_valid ? sdc_pkg::WEEK_SUM_W'(rd_data_ff) : '0)
                  + (keep ? sdc_pkg::WEEK_SUM_W'(mean_ff) : '0);
         count_in = count_ff - sdc_pkg::WEEK_CNT_W'(old_valid)
                  + sdc_pkg::WEEK_CNT_W'(keep);
         valid_in[pos_ff] = keep;
         if (pos_ff == sdc_pkg::WEEK_IDX_W'(sdc_pkg::WEEK_DEPTH - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pos_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      mean_ff <= mean_in;
   end

   always_ff @(posedge clock) begin
      if (req.push) begin
         rd_data_ff <= mem[pos_ff];
      end
      if (phase_ff) begin
         mem[pos_ff] <= mean_ff;
      end
   end

   assign sts.done  = done_ff;
   assign sts.sum   = sum_ff;
   assign sts.count = count_ff;

endmodule

### design/smoke_dust_drift_corrector.sv
// Serial datapath: a 7-step multiply and a 32-step divide per sample; a sample that
// closes an hour also has the shared serial divider run the hour mean and then, as
// needed, week mean, rise test and new factor in turn.
// One sample at a time; the next is taken as soon as the sequencer is idle,
// while the previous result waits in the output register.
// Reset is synchronous; the week ring is emptied through its valid bits at once.
`timescale 1ns / 1ps
`include "smoke_dust_drift_corrector_defines.svh"

module smoke_dust_drift_corrector (
   input  logic                           clock,
   input  logic                           reset,
   sdc_req_if.sink                        req_ch,
   sdc_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [sdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sdc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sdc_pkg::state_type state_ff, state_in;
   logic               start_ff, start_in;

   logic [15:0]                   thr_ff, thr_in;
   logic [15:0]                   sph_ff, sph_in;
   logic                          force_ff, force_in;

   logic [sdc_pkg::SAMPLE_W-1:0]  raw_ff, raw_in;
   logic [sdc_pkg::FACTOR_W-1:0]  factor_ff, factor_in;
   logic [sdc_pkg::FACTOR_W-1:0]  used_ff, used_in;
   logic [15:0]                   la_ff, la_in;
   logic [31:0]                   total_ff, total_in;
   logic [15:0]                   tick_ff, tick_in;
   logic [sdc_pkg::HOURS_W-1:0]   hours_ff, hours_in;
   logic                          close_ff, close_in;
   logic                          removed_ff, removed_in;
   logic                          recalc_ff, recalc_in;
   logic [sdc_pkg::CORR_W-1:0]    corr_ff, corr_in;
   logic [15:0]                   mean_ff, mean_in;
   logic [15:0]                   wm_ff, wm_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sdc_pkg::CORR_W-1:0]    rsp_corr_ff, rsp_corr_in;
   logic [sdc_pkg::FACTOR_W-1:0]  rsp_factor_ff, rsp_factor_in;
   logic                          rsp_removed_ff, rsp_removed_in;
   logic                          rsp_closed_ff, rsp_closed_in;
   logic                          rsp_recalc_ff, rsp_recalc_in;

   sdc_pkg::mul_req_type          mul_req;
   sdc_pkg::div_req_type          div_req;
   sdc_pkg::week_req_type         week_req;
   sdc_pkg::week_sts_type         week_sts;
   logic                          mul_done;
   logic [sdc_pkg::PROD_W-1:0]    mul_prod;
   logic                          div_done;
   logic [31:0]                   div_quo;

   logic                          accept;
   logic                          clean;
   logic [15:0]                   la_eff;
   logic [15:0]                   tick_inc;
   logic                          out_free;
   logic                          full;
   logic [sdc_pkg::HOURS_W-1:0]   hours_inc;

   assign accept    = req_ch.valid && req_ch.ready;
   assign la_eff    = (la_ff == '0) ? thr_ff : la_ff;
   assign tick_inc  = (tick_ff != 16'hFFFF) ? tick_ff + 1'b1 : tick_ff;
   assign clean     = (factor_ff != sdc_pkg::FACTOR_UNITY)
                   && ({1'b0, req_ch.raw_sample} <= {1'b0, thr_ff} + sdc_pkg::CLEAN_MARGIN);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign full      = (week_sts.count == sdc_pkg::WEEK_CNT_W'(sdc_pkg::WEEK_DEPTH));
   assign hours_inc = hours_ff + 1'b1;

   sdc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_prod)
   );

   sdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   sdc_week u_week (
      .clock (clock),
      .reset (reset),
      .req   (week_req),
      .sts   (week_sts)
   );

   // operand selection for the shared serial units
   always_comb begin
      mul_req.start = start_ff && (state_ff == sdc_pkg::ST_MUL_C
                                || state_ff == sdc_pkg::ST_MUL_R
                                || state_ff == sdc_pkg::ST_MUL_F);
      mul_req.a     = raw_ff;
      mul_req.b     = sdc_pkg::FACTOR_UNITY;
      div_req.start    = start_ff && (state_ff == sdc_pkg::ST_DIV_C
                                   || state_ff == sdc_pkg::ST_DIV_H
                                   || state_ff == sdc_pkg::ST_DIV_W
                                   || state_ff == sdc_pkg::ST_DIV_R
                                   || state_ff == sdc_pkg::ST_DIV_F);
      div_req.dividend = 32'(mul_prod);
      div_req.divisor  = 16'd100;
      case (state_ff)
         sdc_pkg::ST_MUL_C: begin
            mul_req.a = raw_ff;
            mul_req.b = used_ff;
         end
         sdc_pkg::ST_MUL_R: begin
            mul_req.a = mean_ff;
         end
         sdc_pkg::ST_MUL_F: begin
            mul_req.a = thr_ff;
         end
         sdc_pkg::ST_DIV_H: begin
            div_req.dividend = total_ff;
            div_req.divisor  = tick_ff;
         end
         sdc_pkg::ST_DIV_W: begin
            div_req.dividend = 32'(week_sts.sum);
            div_req.divisor  = 16'(week_sts.count);
         end
         sdc_pkg::ST_DIV_R: begin
            div_req.divisor = la_ff;
         end
         sdc_pkg::ST_DIV_F: begin
            div_req.divisor = wm_ff;
         end
         default: begin
         end
      endcase
      week_req.clear = accept && clean;
      week_req.push  = start_ff && (state_ff == sdc_pkg::ST_PUSH);
      week_req.mean  = mean_ff;
   end

   always_comb begin
      state_in   = state_ff;
      start_in   = 1'b0;
      thr_in     = thr_ff;
      sph_in     = sph_ff;
      force_in   = force_ff;
      raw_in     = raw_ff;
      factor_in  = factor_ff;
      used_in    = used_ff;
      la_in      = la_ff;
      total_in   = total_ff;
      tick_in    = tick_ff;
      hours_in   = hours_ff;
      close_in   = close_ff;
      removed_in = removed_ff;
      recalc_in  = recalc_ff;
      corr_in    = corr_ff;
      mean_in    = mean_ff;
      wm_in      = wm_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_corr_in    = rsp_corr_ff;
      rsp_factor_in  = rsp_factor_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_closed_in  = rsp_closed_ff;
      rsp_recalc_in  = rsp_recalc_ff;

      if (csr_we) begin
         case (csr_index)
            sdc_pkg::CSR_THRESHOLD: thr_in   = csr_wdata;
            sdc_pkg::CSR_SPH:       sph_in   = csr_wdata;
            sdc_pkg::CSR_FORCE:     force_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         sdc_pkg::ST_IDLE: begin
            if (accept) begin
               raw_in     = req_ch.raw_sample;
               removed_in = clean;
               recalc_in  = 1'b0;
               if (clean) begin
                  factor_in = sdc_pkg::FACTOR_UNITY;
                  used_in   = sdc_pkg::FACTOR_UNITY;
                  la_in     = thr_ff;
               end else begin
                  used_in = factor_ff;
                  la_in   = la_eff;
               end
               total_in = total_ff + 32'(req_ch.raw_sample);
               tick_in  = tick_inc;
               close_in = (tick_inc >= sph_ff);
               state_in = sdc_pkg::ST_MUL_C;
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_MUL_C: begin
            if (mul_done) begin
               state_in = sdc_pkg::ST_DIV_C;
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_DIV_C: begin
            if (div_done) begin
               corr_in = div_quo[sdc_pkg::CORR_W-1:0];
               if (close_ff) begin
                  state_in = sdc_pkg::ST_DIV_H;
                  start_in = 1'b1;
               end else begin
                  state_in = sdc_pkg::ST_DEC;
               end
            end
         end
         sdc_pkg::ST_DIV_H: begin
            if (div_done) begin
               mean_in  = div_quo[15:0];
               total_in = '0;
               tick_in  = '0;
               state_in = sdc_pkg::ST_PUSH;
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_PUSH: begin
            if (week_sts.done) begin
               if (!(full || force_ff)) begin
                  close_in = close_ff;
                  state_in = sdc_pkg::ST_DEC;
                  // mark the decision as done: nothing more for this hour
                  hours_in = hours_ff;
                  wm_in    = wm_ff;
                  recalc_in = 1'b0;
                  // fall straight to the result
                  state_in = sdc_pkg::ST_DEC;
               end else begin
                  hours_in = hours_inc;
                  if (week_sts.count != '0) begin
                     state_in = sdc_pkg::ST_DIV_W;
                     start_in = 1'b1;
                  end else begin
                     wm_in = '0;
                     state_in = sdc_pkg::ST_MUL_R;
                     // decide right here: day boundary or zero average go recalc
                     if (hours_inc == sdc_pkg::HOURS_W'(sdc_pkg::DAY_HOURS)
                         || la_ff == '0) begin
                        factor_in = sdc_pkg::FACTOR_MAX;
                        la_in     = mean_ff;
                        hours_in  = '0;
                        recalc_in = 1'b1;
                        state_in  = sdc_pkg::ST_DEC;
                     end else begin
                        start_in = 1'b1;
                     end
                  end
               end
            end
         end
         sdc_pkg::ST_DIV_W: begin
            if (div_done) begin
               wm_in = div_quo[15:0];
               if (hours_ff == sdc_pkg::HOURS_W'(sdc_pkg::DAY_HOURS) || la_ff == '0) begin
                  state_in = sdc_pkg::ST_MUL_F;
               end else begin
                  state_in = sdc_pkg::ST_MUL_R;
               end
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_MUL_R: begin
            if (mul_done) begin
               state_in = sdc_pkg::ST_DIV_R;
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_DIV_R: begin
            if (div_done) begin
               if (div_quo > sdc_pkg::RISE_LIMIT) begin
                  if (wm_ff == '0) begin
                     factor_in = sdc_pkg::FACTOR_MAX;
                     la_in     = mean_ff;
                     hours_in  = '0;
                     recalc_in = 1'b1;
                     state_in  = sdc_pkg::ST_DEC;
                  end else begin
                     state_in = sdc_pkg::ST_MUL_F;
                     start_in = 1'b1;
                  end
               end else begin
                  state_in = sdc_pkg::ST_DEC;
               end
            end
         end
         sdc_pkg::ST_MUL_F: begin
            if (mul_done) begin
               state_in = sdc_pkg::ST_DIV_F;
               start_in = 1'b1;
            end
         end
         sdc_pkg::ST_DIV_F: begin
            if (div_done) begin
               if (div_quo < 32'(sdc_pkg::FACTOR_MIN)) begin
                  factor_in = sdc_pkg::FACTOR_MIN;
               end else if (div_quo > 32'(sdc_pkg::FACTOR_MAX)) begin
                  factor_in = sdc_pkg::FACTOR_MAX;
               end else begin
                  factor_in = div_quo[sdc_pkg::FACTOR_W-1:0];
               end
               la_in     = mean_ff;
               hours_in  = '0;
               recalc_in = 1'b1;
               state_in  = sdc_pkg::ST_DEC;
            end
         end
         sdc_pkg::ST_DEC: begin
            // hand the item to the output register once it is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_corr_in    = corr_ff;
               rsp_factor_in  = used_ff;
               rsp_removed_in = removed_ff;
               rsp_closed_in  = close_ff;
               rsp_recalc_in  = recalc_ff;
               state_in       = sdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdc_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         thr_ff       <= '0;
         sph_ff       <= 16'd360;
         force_ff     <= 1'b0;
         factor_ff    <= sdc_pkg::FACTOR_UNITY;
         la_ff        <= '0;
         total_ff     <= '0;
         tick_ff      <= '0;
         hours_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         thr_ff       <= thr_in;
         sph_ff       <= sph_in;
         force_ff     <= force_in;
         factor_ff    <= factor_in;
         la_ff        <= la_in;
         total_ff     <= total_in;
         tick_ff      <= tick_in;
         hours_ff     <= hours_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff         <= raw_in;
      used_ff        <= used_in;
      close_ff       <= close_in;
      removed_ff     <= removed_in;
      recalc_ff      <= recalc_in;
      corr_ff        <= corr_in;
      mean_ff        <= mean_in;
      wm_ff          <= wm_in;
      rsp_corr_ff    <= rsp_corr_in;
      rsp_factor_ff  <= rsp_factor_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_closed_ff  <= rsp_closed_in;
      rsp_recalc_ff  <= rsp_recalc_in;
   end

   assign req_ch.ready                = (state_ff == sdc_pkg::ST_IDLE);
   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.corrected_value      = rsp_corr_ff;
   assign rsp_ch.correction_factor    = rsp_factor_ff;
   assign rsp_ch.dust_removed         = rsp_removed_ff;
   assign rsp_ch.hour_closed          = rsp_closed_ff;
   assign rsp_ch.factor_recalculated  = rsp_recalc_ff;

   `SDC_ASSERT_NOW(a_factor_range, clock, reset, 1'b1, factor_ff >= sdc_pkg::FACTOR_MIN && factor_ff <= sdc_pkg::FACTOR_MAX)
   `SDC_ASSERT_NOW(a_recalc_needs_close, clock, reset, rsp_valid_ff && rsp_recalc_ff, rsp_closed_ff)
   `SDC_ASSERT_NOW(a_removed_unity, clock, reset, rsp_valid_ff && rsp_removed_ff, rsp_factor_ff == sdc_pkg::FACTOR_UNITY)
   `SDC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff == sdc_pkg::ST_MUL_C)

endmodule
